[rtl/nearest_point_search_3d_macros.svh]
// Assertion macros used by the checker of the nearest point search block.
// Each one samples on i_clk and is disabled while i_rst_n is low.
`ifndef NEAREST_POINT_SEARCH_3D_MACROS_SVH
`define NEAREST_POINT_SEARCH_3D_MACROS_SVH

// Same-cycle implication.
`define NPS3D_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define NPS3D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/nps3d_pkg.sv]
`default_nettype none
package nps3d_pkg;

    // Table and coordinate geometry
    localparam int MAX_ENTRIES = 64;
    localparam int COORD_BITS  = 24;
    localparam int IDX_BITS    = 6;
    localparam int ADDR_BITS   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // Distance datapath widths: difference, one square, sum of three squares
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * COORD_BITS + 1;
    localparam int DIST_BITS = SQ_BITS + 2;

    // Table word holds x, y, z side by side
    localparam int ENTRY_BITS = 3 * COORD_BITS;

    // Request kinds
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                         action;
        logic [IDX_BITS-1:0]          entry_index;
        logic                         entry_valid;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
    } t_req;

    typedef struct packed {
        logic                found;
        logic [IDX_BITS-1:0] nearest_index;
    } t_rsp;

endpackage
`default_nettype wire

[rtl/nps3d_ram.sv]
`default_nettype none
module nps3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                          i_clk,
    input  wire                                          i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                             i_wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/nearest_point_search_3d.sv]
`default_nettype none
// Nearest point search over a table of 3D probe positions (Q16.8 per axis).
// Request channel: i_req is taken at a rising edge where start is high and
// busy is low. A write request (action = write) stores or removes one table
// slot in that cycle and leaves busy low, so requests may follow back to back.
// A query request raises busy and scans all 64 slots, one slot per cycle,
// through a pipelined distance unit (table read, axis differences, squares,
// sum, compare). The result appears on o_rsp with o_strobe high for exactly
// one cycle, and busy drops on the edge that raises o_strobe, so the next
// query can be taken while the result shows.
// The receiver has no stall: a result is taken in the cycle it is shown.
// found is low and nearest_index zero when no slot is present; ties go to the
// lowest slot. Reset clears all present marks at once (no clearing pass); the
// coordinate memory keeps its contents and is only used behind a present mark.
module nearest_point_search_3d (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      start,
    input  wire nps3d_pkg::t_req     i_req,
    output logic                     busy,
    output logic                     o_strobe,
    output nps3d_pkg::t_rsp          o_rsp
);
    import nps3d_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN} t_state;

    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(MAX_ENTRIES - 1);

    t_state r_state;
    logic   accept;
    logic   wr_en;

    logic [ADDR_BITS-1:0]  r_addr;
    logic [ENTRY_BITS-1:0] ram_rdata;
    logic [ADDR_BITS-1:0]  ram_raddr;
    logic [ENTRY_BITS-1:0] ram_wdata;
    logic [ADDR_BITS-1:0]  ram_waddr;
    logic                  r_present [MAX_ENTRIES];

    logic signed [COORD_BITS-1:0] r_qx, r_qy, r_qz;

    // Pipeline tags: valid, slot, last-slot marker, present
    logic                 r_v0, r_v1, r_v2, r_v3;
    logic                 r_last0, r_last1, r_last2, r_last3;
    logic                 r_p1, r_p2, r_p3;
    logic [ADDR_BITS-1:0] r_idx0, r_idx1, r_idx2, r_idx3;

    logic signed [DIFF_BITS-1:0]   r_dx, r_dy, r_dz;
    logic signed [2*DIFF_BITS-1:0] prod_x, prod_y, prod_z;
    logic [SQ_BITS-1:0]            r_sqx, r_sqy, r_sqz;
    logic [DIST_BITS-1:0]          r_dist;

    logic                 r_found, n_found;
    logic [ADDR_BITS-1:0] r_best, n_best;
    logic [DIST_BITS-1:0] r_best_d, n_best_d;

    logic signed [COORD_BITS-1:0] ent_x, ent_y, ent_z;

    logic   r_out_valid;
    t_rsp   r_rsp;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign o_strobe = r_out_valid;
    assign o_rsp    = r_rsp;

    // Table write path
    assign wr_en     = accept && (i_req.action == ACT_WRITE)
                       && (32'(i_req.entry_index) < MAX_ENTRIES);
    assign ram_waddr = ADDR_BITS'(i_req.entry_index);
    assign ram_wdata = {i_req.pos_x, i_req.pos_y, i_req.pos_z};
    assign ram_raddr = r_addr;

    nps3d_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ent_x = $signed(ram_rdata[3*COORD_BITS-1:2*COORD_BITS]);
    assign ent_y = $signed(ram_rdata[2*COORD_BITS-1:COORD_BITS]);
    assign ent_z = $signed(ram_rdata[COORD_BITS-1:0]);

    // Squares of the registered differences
    assign prod_x = r_dx * r_dx;
    assign prod_y = r_dy * r_dy;
    assign prod_z = r_dz * r_dz;

    // Running minimum; a later slot wins only if strictly nearer
    always_comb begin
        n_found  = r_found;
        n_best   = r_best;
        n_best_d = r_best_d;
        if (r_v3 && r_p3 && (!r_found || (r_dist < r_best_d))) begin
            n_found  = 1'b1;
            n_best   = r_idx3;
            n_best_d = r_dist;
        end
    end

    // Present marks and valid tags of the distance pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_present[i] <= 1'b0;
            end
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (wr_en) begin
                r_present[ram_waddr] <= i_req.entry_valid;
            end
            r_v0 <= (r_state == S_SCAN);
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Distance pipeline payload
    always_ff @(posedge i_clk) begin
        // stage 0: slot address issued to the memory
        r_idx0  <= r_addr;
        r_last0 <= (r_addr == LAST_ADDR);
        // stage 1: axis differences
        r_dx    <= DIFF_BITS'(ent_x) - DIFF_BITS'(r_qx);
        r_dy    <= DIFF_BITS'(ent_y) - DIFF_BITS'(r_qy);
        r_dz    <= DIFF_BITS'(ent_z) - DIFF_BITS'(r_qz);
        r_idx1  <= r_idx0;
        r_last1 <= r_last0;
        r_p1    <= r_present[r_idx0];
        // stage 2: squares
        r_sqx   <= SQ_BITS'(prod_x);
        r_sqy   <= SQ_BITS'(prod_y);
        r_sqz   <= SQ_BITS'(prod_z);
        r_idx2  <= r_idx1;
        r_last2 <= r_last1;
        r_p2    <= r_p1;
        // stage 3: squared distance
        r_dist  <= DIST_BITS'(r_sqx) + DIST_BITS'(r_sqy) + DIST_BITS'(r_sqz);
        r_idx3  <= r_idx2;
        r_last3 <= r_last2;
        r_p3    <= r_p2;
    end

    // Sequencer, running minimum and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
            r_found     <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            r_found     <= n_found;
            r_best      <= n_best;
            r_best_d    <= n_best_d;
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_req.action == ACT_QUERY)) begin
                        r_state <= S_SCAN;
                        r_addr  <= '0;
                        r_found <= 1'b0;
                        r_best  <= '0;
                        r_qx    <= i_req.pos_x;
                        r_qy    <= i_req.pos_y;
                        r_qz    <= i_req.pos_z;
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST_ADDR) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_v3 && r_last3) begin
                        r_state             <= S_IDLE;
                        r_out_valid         <= 1'b1;
                        r_rsp.found         <= n_found;
                        r_rsp.nearest_index <= n_found ? IDX_BITS'(n_best) : '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/nps3d_chk.sv]
`default_nettype none
`include "nearest_point_search_3d_macros.svh"
module nps3d_chk (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  start,
    input wire nps3d_pkg::t_req i_req,
    input wire                  busy,
    input wire                  o_strobe,
    input wire nps3d_pkg::t_rsp o_rsp
);
    import nps3d_pkg::*;

    logic query_acc;
    logic write_acc;

    assign query_acc = start && !busy && (i_req.action == ACT_QUERY);
    assign write_acc = start && !busy && (i_req.action == ACT_WRITE);

    // A query holds the block busy on the following cycle
    `NPS3D_ASSERT_NEXT(a_query_busy, query_acc, busy, "query did not raise busy")
    // A write finishes at once and never yields a result
    `NPS3D_ASSERT_NEXT(a_write_quiet, write_acc, !busy && !o_strobe, "write stalled or answered")
    // The result shows as the scan ends, with busy already released
    `NPS3D_ASSERT_NOW(a_strobe_idle, o_strobe, !busy, "result shown while busy")
    // Results never come in consecutive cycles
    `NPS3D_ASSERT_NEXT(a_strobe_single, o_strobe, !o_strobe, "result repeated")
    // Empty-table answer reports slot zero
    `NPS3D_ASSERT_NOW(a_empty_zero, o_strobe && !o_rsp.found, o_rsp.nearest_index == '0, "not-found result with nonzero slot")

endmodule

bind nearest_point_search_3d nps3d_chk u_nps3d_chk (.*);
`default_nettype wire
